// ----- design/assert_macros.svh -----
// Assertion macros used by the top level of the single-bin DFT magnitude block.
// Both macros sample on the rising clock edge and are disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sbdm_pkg.sv -----
// Package for the single-bin DFT magnitude block: fixed constants, queue status
// and back-end state types. It depends on nothing else.
`default_nettype none

package sbdm_pkg;

    // Width of a sine or cosine table value in Q1.17. It must hold +131072.
    localparam int TAB_W = 19;
    // Right shift that is applied to each sample-times-table product.
    localparam int FRAC_SHIFT = 17;
    // Width of the configuration write data.
    localparam int CFG_WIDTH = 32;

    // Constants for building the sine and cosine table.
    localparam int SERIES_TERMS = 12;
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;
    // Divisors (2i-1)*2i for cosine terms and 2i*(2i+1) for sine terms.
    localparam int COS_DIV [SERIES_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                              462, 552};
    localparam int SIN_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
                                              506, 600};

    // Result queue between the front end and the back end. The depth is a power of two.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                empty;
        logic [Q_CNT_W-1:0]  count;
    } t_q_stat;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQ_RE,
        BK_SQ_IM,
        BK_ROOT,
        BK_OUT
    } t_back_state;

endpackage

`default_nettype wire

// ----- design/sbdm_if.sv -----
// Valid/ready stream interfaces for the sample input and the result output.
// They stand alone and depend on nothing else.
`default_nettype none

// Sample stream: one request carries one sample and its end-of-burst flag.
interface sbdm_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result stream: one request carries the magnitude and both sums of a burst.
interface sbdm_out_if #(
    parameter int ACC_WIDTH = 48
) ();
    logic                        valid;
    logic                        ready;
    logic [ACC_WIDTH-1:0]        magnitude;
    logic signed [ACC_WIDTH-1:0] real_sum;
    logic signed [ACC_WIDTH-1:0] imag_sum;

    modport source (output valid, output magnitude, output real_sum, output imag_sum,
                    input ready);
    modport sink   (input valid, input magnitude, input real_sum, input imag_sum,
                    output ready);
endinterface

`default_nettype wire

// ----- design/sbdm_rom.sv -----
// Cosine and sine table with a registered read port.
// The contents are built at elaboration from constants in sbdm_pkg.
`default_nettype none

module sbdm_rom #(
    parameter int TABLE_INDEX_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [TABLE_INDEX_BITS-1:0]         i_addr,
    output logic signed [sbdm_pkg::TAB_W-1:0]   o_cos,
    output logic signed [sbdm_pkg::TAB_W-1:0]   o_sin
);

    localparam int TAB_SIZE = 1 << TABLE_INDEX_BITS;
    localparam int RES_BITS = TABLE_INDEX_BITS - 2;
    localparam int ENTRY_W  = 2 * sbdm_pkg::TAB_W;

    typedef logic [ENTRY_W-1:0] t_rom [TAB_SIZE];

    // Clamp a Q31 series value to [0, 1.0] and round it to Q17.
    function automatic logic signed [sbdm_pkg::TAB_W-1:0] to_q17(input longint v);
        longint c;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > 64'sd2147483648) begin
            c = 64'sd2147483648;
        end
        return sbdm_pkg::TAB_W'((c + 64'sd8192) >>> 14);
    endfunction

    // Taylor series over the first quadrant, then rotation into the quadrant.
    function automatic t_rom build_rom();
        t_rom                              rom;
        logic [63:0]                       x;
        logic [63:0]                       x2;
        logic [63:0]                       tc;
        logic [63:0]                       ts;
        longint                            sc;
        longint                            ss;
        logic signed [sbdm_pkg::TAB_W-1:0] c;
        logic signed [sbdm_pkg::TAB_W-1:0] s;
        logic [1:0]                        quad;
        for (int k = 0; k < TAB_SIZE; k++) begin
            quad = 2'(k >> RES_BITS);
            x    = (sbdm_pkg::HALF_PI_Q31 * 64'(k & ((1 << RES_BITS) - 1))) >> RES_BITS;
            x2   = (x * x) >> 31;
            tc   = sbdm_pkg::Q31_ONE;
            ts   = x;
            sc   = longint'(tc);
            ss   = longint'(ts);
            for (int i = 0; i < sbdm_pkg::SERIES_TERMS; i++) begin
                tc = ((tc * x2) >> 31) / 64'(sbdm_pkg::COS_DIV[i]);
                ts = ((ts * x2) >> 31) / 64'(sbdm_pkg::SIN_DIV[i]);
                if ((i & 1) == 0) begin
                    sc = sc - longint'(tc);
                    ss = ss - longint'(ts);
                end else begin
                    sc = sc + longint'(tc);
                    ss = ss + longint'(ts);
                end
            end
            c = to_q17(sc);
            s = to_q17(ss);
            unique case (quad)
                2'd0: rom[k] = {c, s};
                2'd1: rom[k] = {-s, c};
                2'd2: rom[k] = {-c, -s};
                2'd3: rom[k] = {s, -c};
                default: rom[k] = {c, s};
            endcase
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [ENTRY_W-1:0] r_data;

    // Synchronous read, one entry per cycle while i_en is high.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= ROM[i_addr];
        end
    end

    assign o_cos = r_data[ENTRY_W-1 -: sbdm_pkg::TAB_W];
    assign o_sin = r_data[sbdm_pkg::TAB_W-1:0];

endmodule

`default_nettype wire

// ----- design/sbdm_front.sv -----
// Front end: takes samples, advances the phase, reads the table, multiplies and
// accumulates with saturation. Uses sbdm_pkg, sbdm_in_if and sbdm_rom.
`default_nettype none

module sbdm_front #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int ACC_WIDTH        = 48,
    parameter int PHASE_WIDTH      = 32,
    parameter int TABLE_INDEX_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbdm_pkg::CFG_WIDTH-1:0]    i_cfg_wdata,
    sbdm_in_if.sink                           i_in,
    input  sbdm_pkg::t_q_stat                 i_q_stat,
    output logic                              o_push,
    output logic [2*ACC_WIDTH-1:0]            o_push_data
);

    localparam int PROD_W = SAMPLE_WIDTH + sbdm_pkg::TAB_W;
    localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam int INF_W  = sbdm_pkg::Q_CNT_W + 1;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum ACC_MAX = {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam t_sum ACC_MIN = {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    // Add a term to an accumulator, clamping at the signed range of the accumulator.
    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input t_prod                       t
    );
        t_sum                        sum;
        logic signed [ACC_WIDTH-1:0] res;
        sum = t_sum'(a) + t_sum'(t);
        priority if (sum > ACC_MAX) begin
            res = ACC_MAX[ACC_WIDTH-1:0];
        end else if (sum < ACC_MIN) begin
            res = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            res = sum[ACC_WIDTH-1:0];
        end
        return res;
    endfunction

    logic                              w_accept;
    logic [INF_W-1:0]                  w_inflight;
    logic [TABLE_INDEX_BITS-1:0]       w_addr;
    logic signed [sbdm_pkg::TAB_W-1:0] w_cos;
    logic signed [sbdm_pkg::TAB_W-1:0] w_sin;
    t_prod                             w_term_re;
    t_prod                             w_term_im;
    logic signed [ACC_WIDTH-1:0]       w_re_next;
    logic signed [ACC_WIDTH-1:0]       w_im_next;

    logic [PHASE_WIDTH-1:0]            r_step;
    logic [PHASE_WIDTH-1:0]            r_phase;
    logic                              r_s1_valid;
    logic                              r_s1_last;
    logic signed [SAMPLE_WIDTH-1:0]    r_s1_sample;
    logic                              r_s2_valid;
    logic                              r_s2_last;
    t_prod                             r_s2_pc;
    t_prod                             r_s2_ps;
    logic signed [ACC_WIDTH-1:0]       r_re_acc;
    logic signed [ACC_WIDTH-1:0]       r_im_acc;

    // Accept only while the queue has room for every end of burst still in flight.
    assign w_inflight = INF_W'(i_q_stat.count)
                      + INF_W'(r_s1_valid & r_s1_last)
                      + INF_W'(r_s2_valid & r_s2_last);
    assign i_in.ready = (w_inflight < INF_W'(sbdm_pkg::Q_DEPTH));
    assign w_accept   = i_in.valid & i_in.ready;

    // Phase step register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cfg_we) begin
            r_step <= PHASE_WIDTH'(i_cfg_wdata);
        end
    end

    // Phase accumulator; it restarts at zero after the last sample of a burst.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= i_in.last ? '0 : (r_phase + r_step);
        end
    end

    assign w_addr = r_phase[PHASE_WIDTH-1 -: TABLE_INDEX_BITS];

    sbdm_rom #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_addr (w_addr),
        .o_cos  (w_cos),
        .o_sin  (w_sin)
    );

    // Stage one holds the sample beside the table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_in.sample;
            r_s1_last   <= i_in.last;
        end
    end

    // Stage two registers both products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_s2_pc   <= t_prod'(r_s1_sample) * t_prod'(w_cos);
        r_s2_ps   <= t_prod'(r_s1_sample) * t_prod'(w_sin);
    end

    // Floor shift of each product; the sine term enters negated.
    assign w_term_re = r_s2_pc >>> sbdm_pkg::FRAC_SHIFT;
    assign w_term_im = -(r_s2_ps >>> sbdm_pkg::FRAC_SHIFT);
    assign w_re_next = sat_add(r_re_acc, w_term_re);
    assign w_im_next = sat_add(r_im_acc, w_term_im);

    // Accumulators clear once the burst result has gone into the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_acc <= '0;
            r_im_acc <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_last) begin
                r_re_acc <= '0;
                r_im_acc <= '0;
            end else begin
                r_re_acc <= w_re_next;
                r_im_acc <= w_im_next;
            end
        end
    end

    assign o_push      = r_s2_valid & r_s2_last;
    assign o_push_data = {w_re_next, w_im_next};

endmodule

`default_nettype wire

// ----- design/sbdm_fifo.sv -----
// Short queue of finished burst sums between the front end and the back end.
// Depth and status type come from sbdm_pkg.
`default_nettype none

module sbdm_fifo #(
    parameter int WIDTH = 96
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output sbdm_pkg::t_q_stat       o_stat
);

    logic [WIDTH-1:0]                 r_mem [sbdm_pkg::Q_DEPTH];
    logic [sbdm_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [sbdm_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [sbdm_pkg::Q_CNT_W-1:0]     r_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

// ----- design/sbdm_back.sv -----
// Back end: takes one burst result from the queue, forms re^2 + im^2 with a
// shift-add multiplier, takes its floor square root bit by bit and holds the
// result for the output. Uses sbdm_pkg and sbdm_out_if.
`default_nettype none

module sbdm_back #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sbdm_pkg::t_q_stat         i_q_stat,
    input  logic [2*ACC_WIDTH-1:0]    i_q_data,
    output logic                      o_pop,
    sbdm_out_if.source                o_out
);

    localparam int CNT_W = $clog2(ACC_WIDTH);
    localparam int N_W   = 2 * ACC_WIDTH;

    function automatic logic [ACC_WIDTH-1:0] abs_val(input logic signed [ACC_WIDTH-1:0] v);
        return v[ACC_WIDTH-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    sbdm_pkg::t_back_state       r_state;
    sbdm_pkg::t_back_state       n_state;

    logic signed [ACC_WIDTH-1:0] w_q_re;
    logic signed [ACC_WIDTH-1:0] w_q_im;
    logic                        w_cnt_last;
    logic [ACC_WIDTH+1:0]        w_rem_sh;
    logic [ACC_WIDTH+1:0]        w_trial;
    logic [ACC_WIDTH+1:0]        w_diff;
    logic                        w_fit;

    logic signed [ACC_WIDTH-1:0] r_re;
    logic signed [ACC_WIDTH-1:0] r_im;
    logic [ACC_WIDTH-1:0]        r_sh;
    logic [N_W-1:0]              r_mc;
    logic [N_W-1:0]              r_n;
    logic [ACC_WIDTH-1:0]        r_rem;
    logic [ACC_WIDTH-1:0]        r_root;
    logic [CNT_W-1:0]            r_cnt;

    assign w_q_re     = i_q_data[N_W-1 -: ACC_WIDTH];
    assign w_q_im     = i_q_data[ACC_WIDTH-1:0];
    assign w_cnt_last = (r_cnt == CNT_W'(ACC_WIDTH - 1));

    // One root digit: bring down two bits and try (root << 2) | 1.
    assign w_rem_sh = {r_rem, r_n[N_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbdm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbdm_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = sbdm_pkg::BK_SQ_RE;
                end
            end
            sbdm_pkg::BK_SQ_RE: begin
                if (w_cnt_last) begin
                    n_state = sbdm_pkg::BK_SQ_IM;
                end
            end
            sbdm_pkg::BK_SQ_IM: begin
                if (w_cnt_last) begin
                    n_state = sbdm_pkg::BK_ROOT;
                end
            end
            sbdm_pkg::BK_ROOT: begin
                if (w_cnt_last) begin
                    n_state = sbdm_pkg::BK_OUT;
                end
            end
            sbdm_pkg::BK_OUT: begin
                if (o_out.ready) begin
                    n_state = sbdm_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = sbdm_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop       = (r_state == sbdm_pkg::BK_IDLE) && !i_q_stat.empty;
        o_out.valid = (r_state == sbdm_pkg::BK_OUT);
    end

    assign o_out.magnitude = r_root;
    assign o_out.real_sum  = r_re;
    assign o_out.imag_sum  = r_im;

    // Datapath: load, two squarings LSB first, then the bitwise square root.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sbdm_pkg::BK_IDLE: begin
                r_re  <= w_q_re;
                r_im  <= w_q_im;
                r_sh  <= abs_val(w_q_re);
                r_mc  <= N_W'(abs_val(w_q_re));
                r_n   <= '0;
                r_cnt <= '0;
            end
            sbdm_pkg::BK_SQ_RE, sbdm_pkg::BK_SQ_IM: begin
                r_n <= r_n + (r_sh[0] ? r_mc : '0);
                if (w_cnt_last) begin
                    r_cnt  <= '0;
                    r_sh   <= abs_val(r_im);
                    r_mc   <= N_W'(abs_val(r_im));
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sh  <= r_sh >> 1;
                    r_mc  <= r_mc << 1;
                end
            end
            sbdm_pkg::BK_ROOT: begin
                r_n    <= r_n << 2;
                r_cnt  <= r_cnt + 1'b1;
                r_rem  <= w_fit ? w_diff[ACC_WIDTH-1:0] : w_rem_sh[ACC_WIDTH-1:0];
                r_root <= {r_root[ACC_WIDTH-2:0], w_fit};
            end
            sbdm_pkg::BK_OUT: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/single_bin_dft_magnitude_top.sv -----
// Single-bin DFT magnitude. One sample is taken per cycle until four burst results
// wait in the 4-entry queue or the pipeline; a burst's sums enter the queue when its
// last sample leaves stage two of the front end. The magnitude unit works on one burst
// at a time, with two shift-add squarings and a one-bit-per-cycle square root, and
// pops the next only once its result has been accepted. Synchronous active-low reset
// clears step, phase, sums and queue; samples are taken right after.
`default_nettype none
`include "assert_macros.svh"

module single_bin_dft_magnitude_top #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int ACC_WIDTH        = 48,
    parameter int PHASE_WIDTH      = 32,
    parameter int TABLE_INDEX_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbdm_pkg::CFG_WIDTH-1:0]    i_cfg_wdata,
    sbdm_in_if.sink                           i_in,
    sbdm_out_if.source                        o_out
);

    localparam int         QW     = sbdm_pkg::Q_CNT_W;
    localparam logic [QW-1:0] Q_FULL = QW'(sbdm_pkg::Q_DEPTH);

    sbdm_pkg::t_q_stat          w_q_stat;
    logic                       w_push;
    logic                       w_pop;
    logic [2*ACC_WIDTH-1:0]     w_push_data;
    logic [2*ACC_WIDTH-1:0]     w_q_data;
    logic [QW-1:0]              w_cnt_inc;

    // Sample stream and accumulation.
    sbdm_front #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .ACC_WIDTH        (ACC_WIDTH),
        .PHASE_WIDTH      (PHASE_WIDTH),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Queue of finished burst sums.
    sbdm_fifo #(
        .WIDTH (2 * ACC_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    // Magnitude and output register.
    sbdm_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_q_data (w_q_data),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // Queue count one step ahead, for the push bookkeeping check.
    assign w_cnt_inc = w_q_stat.count + QW'(1);

    // Queue bookkeeping between the two halves.
    `SBDM_ASSERT_NOW(a_push_room, i_clk, i_rst_n, w_push,
        w_q_stat.count != Q_FULL, "push into a full result queue")
    `SBDM_ASSERT_NOW(a_pop_data, i_clk, i_rst_n, w_pop,
        !w_q_stat.empty, "pop from an empty result queue")
    `SBDM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        w_q_stat.count <= Q_FULL, "result queue count out of range")
    `SBDM_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_push && !w_pop,
        w_q_stat.count == $past(w_cnt_inc), "queue count missed a push")

endmodule

`default_nettype wire
